// File: rtl/core/psf_pkg.sv
// Shared constants, codes and the arctangent table for the polyline segment feature block.
package psf_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // 32-bit binary angle accumulator, full turn = 2^32
    localparam int          ANGLE_ACC_W = 32;
    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;

    // CORDIC gain compensation, round(K * 2^30)
    localparam int                 K_WIDTH = 30;
    localparam logic [K_WIDTH-1:0] K_GAIN  = 30'd652032874;

    localparam int ATAN_IW = 5;

    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_END   = 1'b1;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_CROSSWALK = 2'd1;

    localparam logic [1:0] SIDE_LEFT    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT   = 2'd1;
    localparam logic [1:0] SIDE_CENTER  = 2'd2;
    localparam logic [1:0] SIDE_INVALID = 2'd3;

    localparam logic REC_SEGMENT = 1'b0;
    localparam logic REC_POLYGON = 1'b1;

    // atan(2^-i) with a full turn = 2^32
    function automatic logic [ANGLE_ACC_W-1:0] atan_entry(input logic [ATAN_IW-1:0] idx);
        logic [ANGLE_ACC_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/core/psf_cordic.sv
// Iterative CORDIC vectoring unit: heading and gain-corrected length of a difference vector.
module psf_cordic import psf_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   dx,
    input  logic signed [COORD_WIDTH:0]   dy,
    output logic                          done,
    output logic [ANGLE_WIDTH-1:0]        heading,
    output logic [COORD_WIDTH-1:0]        length
);

    localparam int GUARD = (COORD_WIDTH < 30) ? (30 - COORD_WIDTH) : 0;
    localparam int XW    = COORD_WIDTH + GUARD + 3;
    localparam int MW    = XW - 1;
    localparam int LW    = 16;
    localparam int HW    = MW - LW;
    localparam int PW    = MW + K_WIDTH;
    localparam int SW    = $clog2(CORDIC_STEPS);
    localparam int LENW  = PW + 1 - K_WIDTH - GUARD;

    typedef enum logic [2:0] {C_IDLE, C_ITER, C_MLO, C_MHI, C_FIN} cstate_t;

    cstate_t                 state_reg;
    logic signed [XW-1:0]    x_reg, y_reg;
    logic [ANGLE_ACC_W-1:0]  z_reg;
    logic [SW-1:0]           step_reg;
    logic                    zero_reg;
    logic [PW-1:0]           acc_reg;
    logic                    done_reg;
    logic [ANGLE_WIDTH-1:0]  heading_reg;
    logic [COORD_WIDTH-1:0]  length_reg;

    logic signed [XW-1:0]    xs, ys, shx, shy;
    logic [ANGLE_ACC_W-1:0]  at, hz;
    logic [MW-1:0]           xm;
    logic [LW+K_WIDTH-1:0]   prod_lo;
    logic [HW+K_WIDTH-1:0]   prod_hi;
    logic [PW:0]             rnd;
    logic [LENW-1:0]         lenw;

    assign xs  = XW'(dx) <<< GUARD;
    assign ys  = XW'(dy) <<< GUARD;
    assign shx = x_reg >>> step_reg;
    assign shy = y_reg >>> step_reg;
    assign at  = atan_entry(ATAN_IW'(step_reg));

    // clamp a negative residual to zero before gain correction
    assign xm      = x_reg[XW-1] ? '0 : x_reg[MW-1:0];
    assign prod_lo = xm[LW-1:0] * K_GAIN;
    assign prod_hi = xm[MW-1:LW] * K_GAIN;

    assign rnd  = {1'b0, acc_reg} + ((PW+1)'(1) << (K_WIDTH + GUARD - 1));
    assign lenw = rnd[PW:K_WIDTH+GUARD];
    assign hz   = z_reg + (ANGLE_ACC_W'(1) << (ANGLE_ACC_W - 1 - ANGLE_WIDTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            // pulse done for one cycle as the final step retires
            done_reg <= (state_reg == C_FIN);
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        zero_reg <= (dx == '0) && (dy == '0);
                        step_reg <= '0;
                        if (xs[XW-1]) begin
                            x_reg <= -xs;
                            y_reg <= -ys;
                            z_reg <= HALF_TURN;
                        end else begin
                            x_reg <= xs;
                            y_reg <= ys;
                            z_reg <= '0;
                        end
                        state_reg <= ((dx == '0) && (dy == '0)) ? C_FIN : C_ITER;
                    end
                end
                C_ITER: begin
                    if (!y_reg[XW-1]) begin
                        x_reg <= x_reg + shy;
                        y_reg <= y_reg - shx;
                        z_reg <= z_reg + at;
                    end else begin
                        x_reg <= x_reg - shy;
                        y_reg <= y_reg + shx;
                        z_reg <= z_reg - at;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(CORDIC_STEPS - 1)) begin
                        state_reg <= C_MLO;
                    end
                end
                C_MLO: begin
                    acc_reg   <= PW'(prod_lo);
                    state_reg <= C_MHI;
                end
                C_MHI: begin
                    acc_reg   <= acc_reg + (PW'(prod_hi) << LW);
                    state_reg <= C_FIN;
                end
                C_FIN: begin
                    if (zero_reg) begin
                        heading_reg <= '0;
                        length_reg  <= '0;
                    end else begin
                        heading_reg <= hz[ANGLE_ACC_W-1 -: ANGLE_WIDTH];
                        length_reg  <= (lenw[LENW-1:COORD_WIDTH] != '0) ? '1
                                                                 : lenw[COORD_WIDTH-1:0];
                    end
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign heading = heading_reg;
    assign length  = length_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == C_IDLE)
        else $error("start while vectoring pass busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_done_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(state_reg) == C_FIN)
        else $error("done raised outside final step");
`endif

endmodule

// File: rtl/core/polyline_segment_features.sv
// Polyline segment feature extractor: segment and polygon records from streamed map points.
// A segment record passes the vectoring loop, the gain multiply (low, then high half),
//   the final step and the pending register (a zero step skips loop and multiply); a polygon
//   record goes from the pending register to the output. A waiting record stalls the input:
//   items that make no record are taken back to back; others wait until their record is out.
// Reset: synchronous active-low aresetn clears the sequencer, output valid and polygon state.
module polyline_segment_features import psf_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic signed [COORD_WIDTH-1:0] s_x,
    input  logic signed [COORD_WIDTH-1:0] s_y,
    input  logic [7:0]                    s_point_type,
    input  logic [1:0]                    s_side,
    input  logic [1:0]                    s_base_kind,
    input  logic [7:0]                    s_polygon_class,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_record_kind,
    output logic signed [COORD_WIDTH-1:0] m_pos_x,
    output logic signed [COORD_WIDTH-1:0] m_pos_y,
    output logic signed [ANGLE_WIDTH-1:0] m_heading,
    output logic [COORD_WIDTH-1:0]        m_length,
    output logic [7:0]                    m_seg_point_type,
    output logic [1:0]                    m_seg_side,
    output logic [7:0]                    m_poly_class,
    output logic                          m_is_intersection,
    output logic                          m_accepted
);

    // ST_IDLE: take one transfer; ST_CALC: wait on the vectoring unit;
    // ST_EMIT: hold the pending record until the output register is free.
    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

    state_t state_reg;

    // previous point of the running polyline
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic [7:0]                    prev_type_reg;
    logic [1:0]                    prev_side_reg;
    logic                          prev_valid_reg;

    // per-side anchor: first point and first-segment heading
    logic signed [COORD_WIDTH-1:0] anchor_x_reg [3];
    logic signed [COORD_WIDTH-1:0] anchor_y_reg [3];
    logic [ANGLE_WIDTH-1:0]        anchor_heading_reg [3];
    logic [2:0]                    side_seen_reg;
    logic [2:0]                    side_has_seg_reg;
    logic [15:0]                   seg_count_reg;

    // record waiting for the output register
    logic                          pend_kind_reg;
    logic signed [COORD_WIDTH-1:0] pend_pos_x_reg, pend_pos_y_reg;
    logic [ANGLE_WIDTH-1:0]        pend_heading_reg;
    logic [COORD_WIDTH-1:0]        pend_length_reg;
    logic [7:0]                    pend_ptype_reg;
    logic [1:0]                    pend_side_reg;
    logic [7:0]                    pend_class_reg;
    logic                          pend_inter_reg;
    logic                          pend_accepted_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_kind_reg;
    logic signed [COORD_WIDTH-1:0] out_pos_x_reg, out_pos_y_reg;
    logic [ANGLE_WIDTH-1:0]        out_heading_reg;
    logic [COORD_WIDTH-1:0]        out_length_reg;
    logic [7:0]                    out_ptype_reg;
    logic [1:0]                    out_side_reg;
    logic [7:0]                    out_class_reg;
    logic                          out_inter_reg;
    logic                          out_accepted_reg;

    logic                          pt_ok, seg_hit, cor_start, cor_done, has_seg;
    logic [1:0]                    anch_sel;
    logic signed [COORD_WIDTH:0]   dx, dy;
    logic [ANGLE_WIDTH-1:0]        cor_heading;
    logic [COORD_WIDTH-1:0]        cor_length;

    assign s_ready = (state_reg == ST_IDLE);

    // A point counts only for a real polygon kind and a valid side; it closes a
    // segment when the previous point belongs to the same run.
    assign pt_ok   = (s_mode == MODE_POINT) && (s_base_kind != KIND_NONE)
                     && (s_side != SIDE_INVALID);
    assign seg_hit = pt_ok && prev_valid_reg && (prev_side_reg == s_side);
    assign cor_start = s_valid && s_ready && seg_hit;

    assign dx = (COORD_WIDTH+1)'(s_x) - (COORD_WIDTH+1)'(prev_x_reg);
    assign dy = (COORD_WIDTH+1)'(s_y) - (COORD_WIDTH+1)'(prev_y_reg);

    // anchor priority: center, then left, then right
    assign anch_sel = side_seen_reg[SIDE_CENTER] ? SIDE_CENTER :
                      (side_seen_reg[SIDE_LEFT] ? SIDE_LEFT : SIDE_RIGHT);
    assign has_seg  = (seg_count_reg != '0);

    psf_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .dx      (dx),
        .dy      (dy),
        .done    (cor_done),
        .heading (cor_heading),
        .length  (cor_length)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            prev_valid_reg   <= 1'b0;
            side_seen_reg    <= '0;
            side_has_seg_reg <= '0;
            seg_count_reg    <= '0;
        end else begin
            // drop valid once the record is taken; ST_EMIT reloads the register instead
            if (out_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_mode == MODE_END) begin
                            // build the polygon record, then clear the polygon state
                            pend_kind_reg     <= REC_POLYGON;
                            pend_pos_x_reg    <= has_seg ? anchor_x_reg[anch_sel] : '0;
                            pend_pos_y_reg    <= has_seg ? anchor_y_reg[anch_sel] : '0;
                            pend_heading_reg  <= (has_seg && side_has_seg_reg[anch_sel])
                                                 ? anchor_heading_reg[anch_sel] : '0;
                            pend_length_reg   <= '0;
                            pend_ptype_reg    <= '0;
                            pend_side_reg     <= '0;
                            pend_class_reg    <= s_polygon_class;
                            pend_inter_reg    <= (s_base_kind == KIND_CROSSWALK);
                            pend_accepted_reg <= has_seg;
                            prev_valid_reg    <= 1'b0;
                            side_seen_reg     <= '0;
                            side_has_seg_reg  <= '0;
                            seg_count_reg     <= '0;
                            if (s_base_kind != KIND_NONE) begin
                                state_reg <= ST_EMIT;
                            end
                        end else if (pt_ok) begin
                            // first point of a side fixes its anchor for the polygon
                            if (!side_seen_reg[s_side]) begin
                                side_seen_reg[s_side] <= 1'b1;
                                anchor_x_reg[s_side]  <= s_x;
                                anchor_y_reg[s_side]  <= s_y;
                            end
                            prev_x_reg    <= s_x;
                            prev_y_reg    <= s_y;
                            prev_type_reg <= s_point_type;
                            if (seg_hit) begin
                                pend_kind_reg     <= REC_SEGMENT;
                                pend_pos_x_reg    <= prev_x_reg;
                                pend_pos_y_reg    <= prev_y_reg;
                                pend_ptype_reg    <= prev_type_reg;
                                pend_side_reg     <= s_side;
                                pend_class_reg    <= '0;
                                pend_inter_reg    <= 1'b0;
                                pend_accepted_reg <= 1'b0;
                                if (seg_count_reg != '1) begin
                                    seg_count_reg <= seg_count_reg + 1'b1;
                                end
                                state_reg <= ST_CALC;
                            end else begin
                                // side change or first point: start a new run
                                prev_side_reg  <= s_side;
                                prev_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    if (cor_done) begin
                        pend_heading_reg <= cor_heading;
                        pend_length_reg  <= cor_length;
                        if (!side_has_seg_reg[pend_side_reg]) begin
                            side_has_seg_reg[pend_side_reg]   <= 1'b1;
                            anchor_heading_reg[pend_side_reg] <= cor_heading;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg    <= 1'b1;
                        out_kind_reg     <= pend_kind_reg;
                        out_pos_x_reg    <= pend_pos_x_reg;
                        out_pos_y_reg    <= pend_pos_y_reg;
                        out_heading_reg  <= pend_heading_reg;
                        out_length_reg   <= pend_length_reg;
                        out_ptype_reg    <= pend_ptype_reg;
                        out_side_reg     <= pend_side_reg;
                        out_class_reg    <= pend_class_reg;
                        out_inter_reg    <= pend_inter_reg;
                        out_accepted_reg <= pend_accepted_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_record_kind     = out_kind_reg;
    assign m_pos_x           = out_pos_x_reg;
    assign m_pos_y           = out_pos_y_reg;
    assign m_heading         = out_heading_reg;
    assign m_length          = out_length_reg;
    assign m_seg_point_type  = out_ptype_reg;
    assign m_seg_side        = out_side_reg;
    assign m_poly_class      = out_class_reg;
    assign m_is_intersection = out_inter_reg;
    assign m_accepted        = out_accepted_reg;

`ifndef NO_ASSERTIONS
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> state_reg == ST_CALC)
        else $error("vectoring result arrived outside calc state");

    a_seg_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_start |=> state_reg == ST_CALC)
        else $error("segment transfer did not enter calc state");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_valid_reg && !m_ready) |=> state_reg == ST_EMIT)
        else $error("pending record left while output register busy");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == REC_POLYGON && !out_accepted_reg)
        |-> (out_pos_x_reg == '0 && out_pos_y_reg == '0 && out_heading_reg == '0))
        else $error("unaccepted polygon record carries an anchor");

    a_seg_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == REC_SEGMENT) |-> out_side_reg != SIDE_INVALID)
        else $error("segment record with invalid side");
`endif

endmodule
